// ===== rtl/core/spirf_pkg.sv =====
// shared types, action codes and an address helper for the spi slave register file
`default_nettype none
package spirf_pkg;

	localparam int unsigned REG_COUNT_DEF = 128;
	localparam int unsigned ACT_W         = 3;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned LADDR_W       = 7;
	localparam int unsigned RW_BIT        = 7;
	localparam int unsigned WRAP_STEPS    = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_SPI_BYTE    = 3'd0,
		ACT_CS_DEASSERT = 3'd1,
		ACT_CS_ASSERT   = 3'd2,
		ACT_LOCAL_WRITE = 3'd3,
		ACT_LOCAL_READ  = 3'd4
	} action_t;

	typedef enum logic {
		KIND_MISO  = 1'b0,
		KIND_LOCAL = 1'b1
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic set_sel;
		logic clr_sel;
		logic load_cmd;
		logic wr_spi;
		logic wr_local;
		logic rd_spi;
		logic rd_local;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t act;
		logic    selected;
		logic    awaiting;
		logic    read_mode;
		logic    cmd_read;
	} status_t;

	// reduce a 7-bit address modulo count by repeated subtraction (count >= 16)
	function automatic logic [LADDR_W-1:0] wrap_addr(logic [LADDR_W-1:0] a,
		int unsigned count);
		logic [LADDR_W-1:0] r;
		r = a;
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (32'(r) >= count) begin
				r = r - LADDR_W'(count);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spirf_ctrl.sv =====
// controller state machine sequencing one item at a time
`default_nettype none
module spirf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire spirf_pkg::status_t sts,
	output spirf_pkg::cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDATA
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   is_read;
	logic   take;

	assign take      = out_valid_q && !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		is_read     = 1'b0;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		if (state_q == ST_EXEC) begin
			unique case (sts.act)
				spirf_pkg::ACT_SPI_BYTE: begin
					if (sts.selected) begin
						if (sts.awaiting) begin
							cmd.load_cmd = 1'b1;
							cmd.rd_spi   = sts.cmd_read;
						end else if (!sts.read_mode) begin
							cmd.wr_spi = 1'b1;
						end else begin
							cmd.rd_spi = 1'b1;
						end
					end
				end
				spirf_pkg::ACT_CS_DEASSERT: cmd.clr_sel  = 1'b1;
				spirf_pkg::ACT_CS_ASSERT:   cmd.set_sel  = 1'b1;
				spirf_pkg::ACT_LOCAL_WRITE: cmd.wr_local = 1'b1;
				spirf_pkg::ACT_LOCAL_READ:  cmd.rd_local = 1'b1;
				default: ;
			endcase
			is_read = cmd.rd_spi || cmd.rd_local;
		end
		cmd.load_out = (state_q == ST_RDATA) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: state_q <= is_read ? ST_RDATA : ST_IDLE;
				ST_RDATA: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spirf_dp.sv =====
// datapath: item capture, transfer state, register store and output register
`default_nettype none
module spirf_dp #(
	parameter int unsigned REG_COUNT = spirf_pkg::REG_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [spirf_pkg::ACT_W-1:0]   action,
	input  wire logic [spirf_pkg::BYTE_W-1:0]  spi_byte,
	input  wire logic [spirf_pkg::LADDR_W-1:0] reg_address,
	input  wire logic [spirf_pkg::BYTE_W-1:0]  local_data,
	input  wire spirf_pkg::cmd_t               cmd,
	output spirf_pkg::status_t                 sts,
	output logic                               result_kind,
	output logic [spirf_pkg::BYTE_W-1:0]       data_byte
);

	localparam int unsigned AW = $clog2(REG_COUNT);

	spirf_pkg::action_t                act_q;
	logic [spirf_pkg::BYTE_W-1:0]      spi_q;
	logic [spirf_pkg::LADDR_W-1:0]     laddr_q;
	logic [spirf_pkg::BYTE_W-1:0]      ldata_q;

	logic [AW-1:0]                     cur_addr_q;
	logic                              selected_q;
	logic                              awaiting_q;
	logic                              read_mode_q;

	logic [spirf_pkg::BYTE_W-1:0]      mem_q [REG_COUNT];
	logic [REG_COUNT-1:0]              valid_q;
	logic [spirf_pkg::BYTE_W-1:0]      rdata_q;
	logic                              rvalid_q;
	spirf_pkg::kind_t                  rkind_q;
	spirf_pkg::kind_t                  kind_q;
	logic [spirf_pkg::BYTE_W-1:0]      byte_q;

	logic [AW-1:0]                     start_addr;
	logic [AW-1:0]                     local_addr;
	logic [AW-1:0]                     spi_addr;
	logic [AW-1:0]                     next_addr;
	logic [AW-1:0]                     wr_addr;
	logic [AW-1:0]                     rd_addr;
	logic [spirf_pkg::BYTE_W-1:0]      wr_data;
	logic                              wr_en;
	logic                              rd_en;

	assign start_addr = AW'(spirf_pkg::wrap_addr(spi_q[spirf_pkg::LADDR_W-1:0], REG_COUNT));
	assign local_addr = AW'(spirf_pkg::wrap_addr(laddr_q, REG_COUNT));
	// command byte of a read returns the start register straight away
	assign spi_addr   = cmd.load_cmd ? start_addr : cur_addr_q;
	assign next_addr  = (spi_addr == AW'(REG_COUNT - 1)) ? '0 : spi_addr + 1'b1;
	assign wr_en      = cmd.wr_spi || cmd.wr_local;
	assign rd_en      = cmd.rd_spi || cmd.rd_local;
	assign wr_addr    = cmd.wr_local ? local_addr : cur_addr_q;
	assign wr_data    = cmd.wr_local ? ldata_q : spi_q;
	assign rd_addr    = cmd.rd_local ? local_addr : spi_addr;

	assign sts.act       = act_q;
	assign sts.selected  = selected_q;
	assign sts.awaiting  = awaiting_q;
	assign sts.read_mode = read_mode_q;
	assign sts.cmd_read  = spi_q[spirf_pkg::RW_BIT];

	assign result_kind = kind_q;
	assign data_byte   = byte_q;

	// item capture and output payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= spirf_pkg::action_t'(action);
			spi_q   <= spi_byte;
			laddr_q <= reg_address;
			ldata_q <= local_data;
		end
		if (cmd.load_out) begin
			kind_q <= rkind_q;
			byte_q <= rvalid_q ? rdata_q : '0;
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q  <= '0;
			selected_q  <= 1'b0;
			awaiting_q  <= 1'b1;
			read_mode_q <= 1'b0;
		end else begin
			if (cmd.set_sel) begin
				selected_q <= 1'b1;
				awaiting_q <= 1'b1;
			end
			if (cmd.clr_sel) begin
				selected_q <= 1'b0;
				awaiting_q <= 1'b1;
			end
			if (cmd.load_cmd) begin
				awaiting_q  <= 1'b0;
				read_mode_q <= spi_q[spirf_pkg::RW_BIT];
				cur_addr_q  <= start_addr;
			end
			if (cmd.wr_spi || cmd.rd_spi) begin
				cur_addr_q <= next_addr;
			end
		end
	end

	// per-entry written flags, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// register store with registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q  <= mem_q[rd_addr];
			rvalid_q <= valid_q[rd_addr];
			rkind_q  <= cmd.rd_local ? spirf_pkg::KIND_LOCAL : spirf_pkg::KIND_MISO;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spi_slave_register_file.sv =====
// spi slave register file: a read adds a read data state, which waits on the output register
// items are taken one at a time; the controller steps capture, execute, read data
// reads go through the store's registered read port, hence the read data state
// the result sits in an output register so the next item is taken while it waits
// asynchronous reset clears transfer state and marks every register as zero, no sweep
`default_nettype none
module spi_slave_register_file #(
	parameter int unsigned REG_COUNT = spirf_pkg::REG_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [spirf_pkg::ACT_W-1:0]   action,
	input  wire logic [spirf_pkg::BYTE_W-1:0]  spi_byte,
	input  wire logic [spirf_pkg::LADDR_W-1:0] reg_address,
	input  wire logic [spirf_pkg::BYTE_W-1:0]  local_data,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               result_kind,
	output logic [spirf_pkg::BYTE_W-1:0]       data_byte
);

	// command and status between sequencer and datapath
	spirf_pkg::cmd_t    cmd;
	spirf_pkg::status_t sts;

	// sequencer: decides what the captured item does
	spirf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: store, address counter, chip select and first-byte flags
	spirf_dp #(
		.REG_COUNT (REG_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.spi_byte    (spi_byte),
		.reg_address (reg_address),
		.local_data  (local_data),
		.cmd         (cmd),
		.sts         (sts),
		.result_kind (result_kind),
		.data_byte   (data_byte)
	);

endmodule
`default_nettype wire

// ===== dv/tb_spi_slave_register_file.sv =====
// testbench for the spi slave register file: random and directed items checked against a predictor
`default_nettype none
module tb_spi_slave_register_file;
	timeunit 1ns;
	timeprecision 1ps;

	import spirf_pkg::*;

	localparam int unsigned REG_COUNT = REG_COUNT_DEF;
	// action codes the block has no use for, it must drop them silently
	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
	// an spi command byte with the read bit set
	localparam logic [BYTE_W-1:0] CMD_READ = 8'h80;
	localparam int LIVE_TARGET = 450;
	// cycles without any handshake before we give up on the block
	localparam int IDLE_LIMIT  = 400;
	// margin after the last reply, covering a read plus the output register
	localparam int TAIL_CYCLES = 20;

	// one item for the input channel; pause holds it back until every reply is in
	typedef struct {
		logic [ACT_W-1:0]   act;
		logic [BYTE_W-1:0]  sb;
		logic [LADDR_W-1:0] ra;
		logic [BYTE_W-1:0]  ld;
		bit                 pause;
	} stim_t;

	// one result as it should leave the output channel
	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
	} reply_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [ACT_W-1:0]     action      = '0;
	logic [BYTE_W-1:0]    spi_byte    = '0;
	logic [LADDR_W-1:0]   reg_address = '0;
	logic [BYTE_W-1:0]    local_data  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 result_kind;
	logic [BYTE_W-1:0]    data_byte;

	spi_slave_register_file #(
		.REG_COUNT(REG_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.spi_byte(spi_byte),
		.reg_address(reg_address),
		.local_data(local_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.data_byte(data_byte)
	);

	// items still to be driven, and replies the predictor says are owed
	stim_t  item_queue[$];
	reply_t owed_replies[$];
	int     errors = 0;

	// shadow of the block's state, kept by the predictor
	logic [BYTE_W-1:0]  shadow_regs [REG_COUNT];
	logic [LADDR_W-1:0] shadow_addr;
	logic               shadow_read;
	logic               shadow_wait_cmd;
	logic               shadow_sel;

	// generator bookkeeping: selection as the stimulus sees it, and items that do something
	bit gen_sel   = 1'b0;
	bit hold_next = 1'b0;
	int live_items = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic logic [LADDR_W-1:0] wrap_index(input int unsigned a);
		return LADDR_W'(a % REG_COUNT);
	endfunction

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 7));
	endfunction

	// cast an int action code to the field width
	function automatic logic [ACT_W-1:0] ACT_ACT_W_CAST(input int unsigned c);
		return ACT_W'(c);
	endfunction

	// register file behavior for one accepted item: update the shadow, owe replies
	task automatic predict_register_access(input stim_t s);
		logic [LADDR_W-1:0] la;
		la = wrap_index(s.ra);
		case (s.act)
			ACT_SPI_BYTE: begin
				if (shadow_sel) begin
					if (shadow_wait_cmd) begin
						// command byte: start address and direction
						shadow_wait_cmd = 1'b0;
						shadow_addr = wrap_index(s.sb[LADDR_W-1:0]);
						shadow_read = s.sb[RW_BIT];
						if (shadow_read) begin
							owed_replies.push_back('{KIND_MISO, shadow_regs[shadow_addr]});
							shadow_addr = wrap_index(shadow_addr + 1);
						end
					end else if (!shadow_read) begin
						shadow_regs[shadow_addr] = s.sb;
						shadow_addr = wrap_index(shadow_addr + 1);
					end else begin
						owed_replies.push_back('{KIND_MISO, shadow_regs[shadow_addr]});
						shadow_addr = wrap_index(shadow_addr + 1);
					end
				end
			end
			ACT_CS_DEASSERT: begin
				shadow_sel = 1'b0;
				shadow_wait_cmd = 1'b1;
			end
			ACT_CS_ASSERT: begin
				shadow_sel = 1'b1;
				shadow_wait_cmd = 1'b1;
			end
			ACT_LOCAL_WRITE: shadow_regs[la] = s.ld;
			ACT_LOCAL_READ: owed_replies.push_back('{KIND_LOCAL, shadow_regs[la]});
			default: ;
		endcase
	endtask

	// append one item; count it unless the block will just drop it
	task automatic queue_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] sb,
		input logic [LADDR_W-1:0] ra, input logic [BYTE_W-1:0] ld);
		stim_t s;
		s = '{act, sb, ra, ld, hold_next};
		hold_next = 1'b0;
		if ((act == ACT_SPI_BYTE && gen_sel) ||
			(act >= ACT_CS_DEASSERT && act <= ACT_LOCAL_READ)) begin
			live_items++;
		end
		if (act == ACT_CS_ASSERT) begin
			gen_sel = 1'b1;
		end else if (act == ACT_CS_DEASSERT) begin
			gen_sel = 1'b0;
		end
		item_queue.push_back(s);
	endtask

	// a local access with a random address, biased to the low registers so reads hit writes
	task automatic queue_local_access();
		logic [LADDR_W-1:0] a;
		a = ($urandom_range(0, 1) != 0) ? LADDR_W'($urandom_range(0, 15)) : LADDR_W'($urandom);
		if ($urandom_range(0, 1) != 0) begin
			queue_item(ACT_LOCAL_WRITE, BYTE_W'($urandom), a, BYTE_W'($urandom));
		end else begin
			queue_item(ACT_LOCAL_READ, BYTE_W'($urandom), a, BYTE_W'($urandom));
		end
	endtask

	// driver: presents items from the queue, predicts each one as it is taken
	stim_t cur_item;
	int    send_gap  = 0;
	bit    send_calm = 1'b0;

	always @(posedge clk) begin
		bit slot_free;
		if (arst_n) begin
			slot_free = !in_valid;
			if (in_valid && !in_stall) begin
				predict_register_access(cur_item);
				slot_free = 1'b1;
				send_gap = draw_wait(send_calm);
				// switch between bursts with no gaps and gappy stretches
				if ($urandom_range(0, 39) == 0) begin
					send_calm = !send_calm;
				end
			end
			if (slot_free) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (item_queue.size() != 0 &&
					!(item_queue[0].pause && owed_replies.size() != 0)) begin
					cur_item = item_queue.pop_front();
					action      <= cur_item.act;
					spi_byte    <= cur_item.sb;
					reg_address <= cur_item.ra;
					local_data  <= cur_item.ld;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes replies under random stall and checks them in order
	int take_gap  = 0;
	bit take_calm = 1'b0;

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected reply kind %0d data %02h",
						result_kind, data_byte));
				end else begin
					want = owed_replies.pop_front();
					if (result_kind !== want.kind) begin
						report_mismatch($sformatf("result_kind %0d, expected %0d",
							result_kind, want.kind));
					end
					if (data_byte !== want.data) begin
						report_mismatch($sformatf("data_byte %02h, expected %02h",
							data_byte, want.data));
					end
				end
				take_gap = draw_wait(take_calm);
				if ($urandom_range(0, 39) == 0) begin
					take_calm = !take_calm;
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long without any handshake on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int n;
		logic [BYTE_W-1:0] cmd;

		// shadow reset: store cleared, waiting for a command, not selected
		for (int i = 0; i < REG_COUNT; i++) begin
			shadow_regs[i] = '0;
		end
		shadow_addr = '0;
		shadow_read = 1'b0;
		shadow_wait_cmd = 1'b1;
		shadow_sel = 1'b0;

		// directed part
		// byte while not selected is dropped
		queue_item(ACT_SPI_BYTE, 8'hff, 7'h7f, 8'hff);
		// write transfer from 126 that wraps past the last register to zero
		queue_item(ACT_CS_ASSERT, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'h7e, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'hff, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'ha5, 7'h00, 8'h00);
		queue_item(ACT_CS_DEASSERT, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'h12, 7'h00, 8'h00);
		// local port at both ends of the address range, data extremes
		queue_item(ACT_LOCAL_READ, 8'h00, 7'h7e, 8'hff);
		queue_item(ACT_LOCAL_WRITE, 8'h00, 7'h7f, 8'hff);
		queue_item(ACT_LOCAL_READ, 8'h00, 7'h7f, 8'h00);
		queue_item(ACT_LOCAL_WRITE, 8'hff, 7'h00, 8'h00);
		queue_item(ACT_LOCAL_READ, 8'hff, 7'h00, 8'hff);
		// assert twice, then a read transfer from 126 across the wrap
		queue_item(ACT_CS_ASSERT, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_CS_ASSERT, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, CMD_READ | 8'h7e, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'h00, 7'h00, 8'h00);
		queue_item(ACT_SPI_BYTE, 8'hff, 7'h00, 8'h00);
		// local write while selected shows up in the ongoing read
		queue_item(ACT_LOCAL_WRITE, 8'h00, 7'h01, 8'h5a);
		queue_item(ACT_SPI_BYTE, 8'h33, 7'h00, 8'h00);
		queue_item(ACT_CS_DEASSERT, 8'h00, 7'h00, 8'h00);
		// unused action codes
		for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++) begin
			queue_item(ACT_ACT_W_CAST(c), 8'hff, 7'h7f, 8'hff);
		end
		// hold the sender until the block has drained
		hold_next = 1'b1;
		queue_item(ACT_LOCAL_READ, 8'h00, 7'h7e, 8'h00);

		// random part: mostly whole transfers, plus local traffic and noise
		while (live_items < LIVE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_item(ACT_CS_ASSERT, BYTE_W'($urandom), LADDR_W'($urandom),
					BYTE_W'($urandom));
				cmd = BYTE_W'($urandom);
				if ($urandom_range(0, 1) != 0) begin
					cmd[LADDR_W-1:0] = LADDR_W'($urandom_range(0, 15));
				end
				queue_item(ACT_SPI_BYTE, cmd, LADDR_W'($urandom), BYTE_W'($urandom));
				// now and then a long burst that can run through the whole store
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 140) : $urandom_range(0, 8);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						queue_local_access();
					end
					queue_item(ACT_SPI_BYTE, BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
				end
				queue_item(ACT_CS_DEASSERT, BYTE_W'($urandom), LADDR_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 78) begin
				queue_local_access();
			end else if (pick < 85) begin
				// stray byte, usually outside a transfer
				queue_item(ACT_SPI_BYTE, BYTE_W'($urandom), LADDR_W'($urandom),
					BYTE_W'($urandom));
			end else if (pick < 90) begin
				queue_item(ACT_ACT_W_CAST($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
					BYTE_W'($urandom), LADDR_W'($urandom), BYTE_W'($urandom));
			end else if (pick < 97) begin
				// broken transfer: restarted by a second assert, or cut short
				queue_item(ACT_CS_ASSERT, BYTE_W'($urandom), LADDR_W'($urandom),
					BYTE_W'($urandom));
				n = $urandom_range(0, 3);
				for (int k = 0; k < n; k++) begin
					queue_item(ACT_SPI_BYTE, BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
				end
				if ($urandom_range(0, 1) != 0) begin
					queue_item(ACT_CS_ASSERT, BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
					queue_item(ACT_SPI_BYTE, CMD_READ | BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
					queue_item(ACT_SPI_BYTE, BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
				end else begin
					queue_item(ACT_CS_DEASSERT, BYTE_W'($urandom), LADDR_W'($urandom),
						BYTE_W'($urandom));
				end
			end else begin
				// let the block drain completely before going on
				hold_next = 1'b1;
				queue_local_access();
			end
		end
		// leave the bus deselected at the end
		queue_item(ACT_CS_DEASSERT, 8'h00, 7'h00, 8'h00);

		// single reset at the start
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item to be taken, then for every reply
		while (item_queue.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (owed_replies.size() != 0) begin
			@(posedge clk);
		end
		// a little longer to catch stray replies
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/spirf_pkg.sv
rtl/core/spirf_ctrl.sv
rtl/core/spirf_dp.sv
rtl/core/spi_slave_register_file.sv
dv/tb_spi_slave_register_file.sv
